// File: src/enhanced_clock_page_replacer_assert.svh
// Assertion macros used by the checker of the page replacer.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_ASSERT_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ecpr_pkg.sv
package ecpr_pkg;

  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 8;
  localparam int unsigned OCC_W     = $clog2(FRAMES + 1);
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned FAULT_W   = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned IN_W     = ((PAGE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 3 + PAGE_BITS + FAULT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Bit positions of the result fields in the output tdata.
  localparam int unsigned HIT_BIT    = 0;
  localparam int unsigned EV_BIT     = 1;
  localparam int unsigned EVPAGE_LSB = 2;
  localparam int unsigned DIRTY_BIT  = EVPAGE_LSB + PAGE_BITS;
  localparam int unsigned FAULT_LSB  = DIRTY_BIT + 1;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_HIT,
    OP_APPEND,
    OP_EVICT
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    op_e   op;
    page_t page;
    logic  wr;
    logic  target;
    logic  any1;
  } ctrl_t;

  // Travels from the front of the list toward the back.
  typedef struct packed {
    logic  valid;
    logic  hit;
    logic  f1;
    logic  f2;
    page_t ev_page;
    logic  ev_dirty;
  } scan_t;

  // What a cell shows to the cell in front of it; registers only.
  typedef struct packed {
    logic  valid;
    page_t page;
    logic  refb;
    logic  mod;
  } nb_t;

endpackage

// File: src/ecpr_cell.sv
module ecpr_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecpr_pkg::ctrl_t ctrl_i,
  input  ecpr_pkg::scan_t scan_i,
  input  ecpr_pkg::nb_t   next_i,
  output ecpr_pkg::scan_t scan_o,
  output ecpr_pkg::nb_t   nb_o
);
  import ecpr_pkg::*;

  logic  valid_q, valid_d;
  logic  refb_q, refb_d;
  logic  mod_q, mod_d;
  page_t page_q, page_d;

  logic match, hit_here, c1, c2, victim, shift, last, first_free;
  logic ref_clr, next_ref_clr;

  always_comb begin
    match    = valid_q && (page_q == ctrl_i.page);
    hit_here = match && !scan_i.hit;
    // c1: candidate in the first pass, c2: candidate once all reference bits are clear.
    c1       = valid_q && !refb_q && (mod_q == ctrl_i.target);
    c2       = valid_q && (mod_q == ctrl_i.target);

    scan_o.valid = valid_q;
    scan_o.hit   = scan_i.hit | match;
    scan_o.f1    = scan_i.f1 | c1;
    scan_o.f2    = scan_i.f2 | c2;

    victim = ctrl_i.any1 ? (c1 && !scan_i.f1) : (c2 && !scan_i.f2);
    shift  = ctrl_i.any1 ? scan_o.f1 : scan_o.f2;

    scan_o.ev_page  = scan_i.ev_page | (victim ? page_q : '0);
    scan_o.ev_dirty = scan_i.ev_dirty | (victim && mod_q);

    // Frames passed by the scan lose their reference bit; frames behind a
    // first-pass victim keep theirs.
    ref_clr      = ctrl_i.any1 && scan_i.f1 && refb_q;
    next_ref_clr = ctrl_i.any1 && scan_o.f1 && next_i.refb;

    last       = valid_q && !next_i.valid;
    first_free = !valid_q && scan_i.valid;

    nb_o.valid = valid_q;
    nb_o.page  = page_q;
    nb_o.refb  = refb_q;
    nb_o.mod   = mod_q;

    valid_d = valid_q;
    refb_d  = refb_q;
    mod_d   = mod_q;
    page_d  = page_q;

    unique case (ctrl_i.op)
      OP_HIT: begin
        if (hit_here) begin
          refb_d = 1'b1;
          mod_d  = mod_q | ctrl_i.wr;
        end
      end
      OP_APPEND: begin
        if (first_free) begin
          valid_d = 1'b1;
          page_d  = ctrl_i.page;
          refb_d  = 1'b1;
          mod_d   = ctrl_i.wr;
        end
      end
      OP_EVICT: begin
        if (last) begin
          page_d = ctrl_i.page;
          refb_d = 1'b1;
          mod_d  = ctrl_i.wr;
        end else if (shift) begin
          page_d = next_i.page;
          refb_d = next_ref_clr;
          mod_d  = next_i.mod;
        end else begin
          refb_d = ref_clr;
        end
      end
      OP_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      refb_q  <= 1'b0;
      mod_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      refb_q  <= refb_d;
      mod_q   <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// File: src/enhanced_clock_page_replacer.sv
// Enhanced second-chance page replacer. Each input beat is one page reference (page number in
// tdata, write flag in tuser) and yields one result beat. For a reference the beat is first
// registered, then the row of frame cells compares, picks a victim over both scan passes,
// shifts and appends together. A stalled output holds back the next reference until the held
// result is taken; one reference can wait in the input register meanwhile. Frames come out of
// reset empty with no clearing pass. frames_in_use may only be written while no reference is
// in flight; 0 acts as 1 and values above the frame count act as the frame count.
module enhanced_clock_page_replacer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ecpr_pkg::CFG_W-1:0]  cfg_wdata_i,   // frames_in_use
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ecpr_pkg::IN_W-1:0]   s_axis_tdata,  // page
  input  logic                        s_axis_tuser,  // write
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit, evicted, evicted_page, evicted_dirty, fault_count, zero fill
  output logic [ecpr_pkg::OUT_W-1:0]  m_axis_tdata
);
  import ecpr_pkg::*;

  localparam int unsigned CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  state_e state_q, state_d;
  page_t  page_q;
  logic   wr_q;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [FAULT_W-1:0] faults_q, faults_d;
  logic [CFG_W-1:0]   cfg_q;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  logic [CMP_W-1:0] cfg_ext, cap, occ_ext;
  logic             exec, hit, need_evict, target;
  ctrl_t            ctrl;
  scan_t            scan [FRAMES+1];
  nb_t              nb   [FRAMES];
  nb_t              nb_empty;

  assign scan[0]  = '{valid: 1'b1, hit: 1'b0, f1: 1'b0, f2: 1'b0,
                      ev_page: '0, ev_dirty: 1'b0};
  assign nb_empty = '{valid: 1'b0, page: '0, refb: 1'b0, mod: 1'b0};

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    ecpr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .scan_i (scan[i]),
      .next_i ((i == FRAMES - 1) ? nb_empty : nb[(i + 1) % FRAMES]),
      .scan_o (scan[i+1]),
      .nb_o   (nb[i])
    );
  end

  always_comb begin
    target = 1'b1;
    for (int i = 0; i < FRAMES; i++) begin
      target = target & (nb[i].mod | ~nb[i].valid);
    end
  end

  always_comb begin
    cfg_ext = CMP_W'(cfg_q);
    occ_ext = CMP_W'(occ_q);
    if (cfg_ext == '0) begin
      cap = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      cap = CMP_W'(FRAMES);
    end else begin
      cap = cfg_ext;
    end
    need_evict = (occ_ext >= cap);
    hit        = scan[FRAMES].hit;
    exec       = (state_q == ST_BUSY) && (!out_valid_q || m_axis_tready);

    ctrl.page   = page_q;
    ctrl.wr     = wr_q;
    ctrl.target = target;
    ctrl.any1   = scan[FRAMES].f1;
    priority if (!exec) begin
      ctrl.op = OP_IDLE;
    end else if (hit) begin
      ctrl.op = OP_HIT;
    end else if (need_evict) begin
      ctrl.op = OP_EVICT;
    end else begin
      ctrl.op = OP_APPEND;
    end

    occ_d    = occ_q;
    faults_d = faults_q;
    if (ctrl.op == OP_APPEND) begin
      occ_d = occ_q + OCC_W'(1);
    end
    if (exec && !hit && (faults_q != FAULT_MAX)) begin
      faults_d = faults_q + FAULT_W'(1);
    end

    out_data_d = OUT_W'({faults_d,
                         (ctrl.op == OP_EVICT) && scan[FRAMES].ev_dirty,
                         (ctrl.op == OP_EVICT) ? scan[FRAMES].ev_page : page_t'(0),
                         ctrl.op == OP_EVICT,
                         hit});
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (exec) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      faults_q    <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      page_q <= s_axis_tdata[PAGE_BITS-1:0];
      wr_q   <= s_axis_tuser;
    end
    if (exec) begin
      out_data_q <= out_data_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: src/ecpr_checker.sv
`include "enhanced_clock_page_replacer_assert.svh"

module ecpr_assert_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ecpr_pkg::OUT_W-1:0]  m_axis_tdata
);
  import ecpr_pkg::*;

  logic in_beat, out_stall, out_hit, out_ev;
  logic [PAGE_BITS:0] out_ev_info;

  assign in_beat     = s_axis_tvalid && s_axis_tready;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_hit     = m_axis_tdata[HIT_BIT];
  assign out_ev      = m_axis_tdata[EV_BIT];
  assign out_ev_info = m_axis_tdata[DIRTY_BIT:EVPAGE_LSB];

  // A held result keeps its value until taken.
  `ECPR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
    m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // Only one reference is taken in at a time; the input closes after each accepted beat.
  `ECPR_ASSERT_NXT(a_one_ref, clk_i, rst_ni, in_beat,
    !s_axis_tready, "input accepted while a reference is in flight")

  // An eviction only happens on a page fault.
  `ECPR_ASSERT_IMP(a_ev_miss, clk_i, rst_ni, m_axis_tvalid && out_ev,
    !out_hit, "eviction reported on a hit")

  // Without an eviction the evicted page and dirty bit read zero.
  `ECPR_ASSERT_IMP(a_ev_zero, clk_i, rst_ni, m_axis_tvalid && !out_ev,
    out_ev_info == '0, "evicted fields set without an eviction")

endmodule

bind enhanced_clock_page_replacer ecpr_assert_checker u_ecpr_checker (.*);
